>>> rtl/vfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_pkg: shared types and codes of the voxel face culler
// Function codes of the input word, face direction codes and sequencer states.
// ----------------------------------------------------------------------------
package vfc_pkg;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_BEGIN = 2'd2;

  localparam int COORD_BITS = 4;
  localparam int COUNT_BITS = 17;
  localparam int OUT_TYPE_BITS = 8;
  localparam int AIR_BITS = 8;
  localparam int NUM_FACES = 6;

  typedef enum logic [2:0] {
    DIR_PZ = 3'd0,
    DIR_NZ = 3'd1,
    DIR_PY = 3'd2,
    DIR_NY = 3'd3,
    DIR_PX = 3'd4,
    DIR_NX = 3'd5
  } face_dir_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

>>> rtl/voxel_face_culler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_culler: culled face meshing over a grid of block types
// Stores a grid of type codes and emits one record per exposed face of a
// queried solid cell, with a running base vertex index.
// ----------------------------------------------------------------------------
// Usage. Input words arrive on s_tvalid/s_tready/s_tdata. A write word stores
// a type code in one cell, a begin word clears the running vertex count, and
// a query word names one cell. Face records leave on m_tvalid/m_tready/
// m_tdata/m_tlast, in the order +Z, -Z, +Y, -Y, +X, -X, with m_tlast set on
// the final record of a query. The user must set the air type through
// cfg_we/cfg_wdata only while the block is idle; the block itself does not enforce this.
// Timing. Write and begin words are taken back to back. A query drops
// s_tready while it scans, because the single-port cell store delivers one
// read per cycle: the cell itself, read twice, and then its six neighbours,
// each checked against the air type by one shared comparator. Emission then
// walks the face directions in order, and s_tready stays low until it is done.
// An air cell ends the scan once its own type is read, and a query of a cell
// outside the grid leaves the block idle. The output register lets the block
// take the next word while the final record still waits. When the receiver
// stalls, emission holds at the current face and no record is lost. Reset
// clears the sequencer, the output valid, the vertex count and the air type;
// the cell store holds no reset value and every cell must be written before
// it is queried.
// ----------------------------------------------------------------------------
module voxel_face_culler
  import vfc_pkg::*;
#(
  parameter int SIZE_X    = 16,
  parameter int SIZE_Y    = 16,
  parameter int SIZE_Z    = 16,
  parameter int TYPE_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  // Configuration: air type code.
  input  logic                cfg_we,
  input  logic [AIR_BITS-1:0] cfg_wdata,
  // Input stream. tdata from bit 0: func[2], cell_x[4], cell_y[4], cell_z[4],
  // write_type[8], two zero bits.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [23:0]         s_tdata,
  // Output stream. tdata from bit 0: face_dir[3], face_x[4], face_y[4],
  // face_z[4], face_type[8], base_vertex[17].
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [39:0]         m_tdata,
  output logic                m_tlast
);

  localparam int DEPTH = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NB    = 9; // neighbour coordinate, wide enough to hold -1 out of range

  // Input word fields.
  logic [1:0]            func;
  logic [COORD_BITS-1:0] in_x, in_y, in_z;
  logic [7:0]            in_type;

  assign func    = s_tdata[1:0];
  assign in_x    = s_tdata[5:2];
  assign in_y    = s_tdata[9:6];
  assign in_z    = s_tdata[13:10];
  assign in_type = s_tdata[21:14];

  // Registers.
  state_t                state, state_next;
  logic [2:0]            step;
  logic [2:0]            dir;
  logic [NUM_FACES-1:0]  mask;
  logic [COORD_BITS-1:0] cx, cy, cz;
  logic [TYPE_BITS-1:0]  own_type;
  logic [TYPE_BITS-1:0]  rd;
  logic                  prev_in;
  logic [COUNT_BITS-1:0] vertex_count;
  logic [AIR_BITS-1:0]   air_type;
  logic [TYPE_BITS-1:0]  mem [DEPTH];

  // Combinational signals.
  logic                  accept;
  logic                  in_grid_in;
  logic [AW-1:0]         in_addr;
  logic [NB-1:0]         nx, ny, nz;
  logic                  n_in_grid;
  logic [AW-1:0]         n_addr;
  logic [AW-1:0]         addr;
  logic                  is_air;
  logic                  out_free;
  logic                  emit_fire;
  logic [NUM_FACES-1:0]  dir_bit;
  logic                  last_face;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign in_grid_in = (32'(in_x) < SIZE_X) && (32'(in_y) < SIZE_Y) && (32'(in_z) < SIZE_Z);
  assign in_addr    = AW'((32'(in_z) * SIZE_Y + 32'(in_y)) * SIZE_X + 32'(in_x));

  // Position read at this scan step: the cell itself, then one neighbour per face.
  always_comb begin
    nx = NB'(cx);
    ny = NB'(cy);
    nz = NB'(cz);
    unique case (step)
      3'd1:    nz = NB'(cz) + NB'(1);
      3'd2:    nz = NB'(cz) - NB'(1);
      3'd3:    ny = NB'(cy) + NB'(1);
      3'd4:    ny = NB'(cy) - NB'(1);
      3'd5:    nx = NB'(cx) + NB'(1);
      3'd6:    nx = NB'(cx) - NB'(1);
      default: ;
    endcase
  end

  assign n_in_grid = (32'(nx) < SIZE_X) && (32'(ny) < SIZE_Y) && (32'(nz) < SIZE_Z);
  assign n_addr    = AW'((32'(nz) * SIZE_Y + 32'(ny)) * SIZE_X + 32'(nx));
  assign addr      = (state == ST_IDLE) ? in_addr : n_addr;

  // The shared comparator: read data against the air type.
  assign is_air = (rd == TYPE_BITS'(air_type));

  assign dir_bit   = NUM_FACES'(1) << dir;
  assign last_face = (mask & ~dir_bit) == '0;
  assign emit_fire = (state == ST_EMIT) && ((mask & dir_bit) != '0) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && func == FUNC_QUERY && in_grid_in) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step == 3'd1 && is_air) begin
          state_next = ST_IDLE;
        end else if (step == 3'd7) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (mask == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Single-port cell store: writes only while idle, reads during the scan.
  always_ff @(posedge clk) begin
    if (accept && func == FUNC_WRITE && in_grid_in) begin
      mem[addr] <= TYPE_BITS'(in_type);
    end
    rd <= mem[addr];
  end

  // Scan and emit datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      cx   <= in_x;
      cy   <= in_y;
      cz   <= in_z;
      step <= '0;
    end
    if (state == ST_SCAN) begin
      step    <= step + 3'd1;
      prev_in <= n_in_grid;
      if (step == 3'd1) begin
        own_type <= rd;
      end
      if (step >= 3'd2) begin
        mask[3'(step - 3'd2)] <= !prev_in || is_air;
      end
      if (step == 3'd7) begin
        dir <= '0;
      end
    end
    if (state == ST_EMIT && (mask & dir_bit) == '0 && dir < 3'(NUM_FACES - 1)) begin
      dir <= dir + 3'd1;
    end
    if (emit_fire) begin
      mask <= mask & ~dir_bit;
      if (dir < 3'(NUM_FACES - 1)) begin
        dir <= dir + 3'd1;
      end
    end
  end

  // Output register, vertex count and air type.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid     <= 1'b0;
      vertex_count <= '0;
      air_type     <= '0;
    end else begin
      if (cfg_we) begin
        air_type <= cfg_wdata;
      end
      if (accept && func == FUNC_BEGIN) begin
        vertex_count <= '0;
      end
      if (emit_fire) begin
        m_tvalid     <= 1'b1;
        vertex_count <= vertex_count + COUNT_BITS'(4);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_tdata <= {vertex_count, OUT_TYPE_BITS'(own_type), cz, cy, cx, dir};
      m_tlast <= last_face;
    end
  end

endmodule

>>> tb/sv/voxel_face_culler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_culler_tb: self-checking bench for the voxel face culler
// Loads cells, runs face queries under several air types and checks each
// face record against a predictor kept in the bench, field by field.
// ----------------------------------------------------------------------------
module voxel_face_culler_tb
  import vfc_pkg::*;
();

  // Grid size of the block under test (its default parameters).
  localparam int GRID_X = 16;
  localparam int GRID_Y = 16;
  localparam int GRID_Z = 16;
  localparam int GRID_CELLS = GRID_X * GRID_Y * GRID_Z;

  // The one code of the func field that the block must ignore.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Idle cycles let pass after the last face record before the air type
  // changes or the run ends.
  localparam int DRAIN_CYCLES = 24;

  // Queries of one isolated cell, each of which shows all six faces.
  localparam int REPEAT_QUERIES = 40;

  // One face record as it leaves on m_tdata, lowest field last.
  typedef struct packed {
    logic [COUNT_BITS-1:0]    base;
    logic [OUT_TYPE_BITS-1:0] ftype;
    logic [COORD_BITS-1:0]    z;
    logic [COORD_BITS-1:0]    y;
    logic [COORD_BITS-1:0]    x;
    face_dir_t                dir;
  } face_rec_t;

  typedef struct packed {
    logic      last;
    face_rec_t rec;
  } face_exp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;  // func[2], cell_x[4], cell_y[4], cell_z[4],
                              // write_type[8], two zero bits
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;       // face_dir[3], face_x[4], face_y[4], face_z[4],
                              // face_type[8], base_vertex[17]
  logic        m_tlast;

  // Predictor state: the cell grid, which cells hold a value, the running
  // vertex count and the air type code.
  logic [7:0]            cell_types [0:GRID_CELLS-1];
  bit                    cell_written [0:GRID_CELLS-1];
  logic [COUNT_BITS-1:0] vtx_count = '0;
  logic [7:0]            air_code = '0;

  // Face records predicted and not yet seen on the output.
  face_exp_t pending_faces [$];

  int error_count = 0;
  int words_sent = 0;
  int burst_left = 0;

  // Receiver stall pattern: open and stalled runs alternate.
  bit rx_open = 1'b0;
  int rx_run = 0;

  face_rec_t got_rec;
  face_exp_t want;

  voxel_face_culler u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic int cell_index(input int x, input int y, input int z);
    return (z * GRID_Y + y) * GRID_X + x;
  endfunction

  function automatic bit in_grid(input int x, input int y, input int z);
    return x >= 0 && x < GRID_X && y >= 0 && y < GRID_Y && z >= 0 && z < GRID_Z;
  endfunction

  // A face is exposed when its neighbour is air or lies outside the grid.
  function automatic bit face_open(input int x, input int y, input int z);
    if (!in_grid(x, y, z)) return 1'b1;
    return cell_types[cell_index(x, y, z)] == air_code;
  endfunction

  // Neighbour across face d; any other value of d names the cell itself.
  task automatic nbr_of(input int d, input int x, input int y, input int z,
                        output int nx, output int ny, output int nz);
    nx = x;
    ny = y;
    nz = z;
    case (d)
      DIR_PZ: nz = z + 1;
      DIR_NZ: nz = z - 1;
      DIR_PY: ny = y + 1;
      DIR_NY: ny = y - 1;
      DIR_PX: nx = x + 1;
      DIR_NX: nx = x - 1;
      default: ;
    endcase
  endtask

  // Applies one accepted word to the predictor state and queues the face
  // records that it causes.
  task automatic predict_faces(input logic [23:0] w);
    logic [1:0] fn;
    int x, y, z, nx, ny, nz, idx;
    logic [5:0] open_mask;
    face_exp_t e;
    fn = w[1:0];
    x = int'(w[5:2]);
    y = int'(w[9:6]);
    z = int'(w[13:10]);
    idx = cell_index(x, y, z);
    case (fn)
      FUNC_BEGIN: vtx_count = '0;
      FUNC_WRITE: begin
        cell_types[idx] = w[21:14];
        cell_written[idx] = 1'b1;
      end
      FUNC_QUERY: begin
        if (cell_types[idx] != air_code) begin
          // First find every exposed face, so the final one can carry last.
          for (int d = 0; d < NUM_FACES; d++) begin
            nbr_of(d, x, y, z, nx, ny, nz);
            open_mask[d] = face_open(nx, ny, nz);
          end
          for (int d = 0; d < NUM_FACES; d++) begin
            if (open_mask[d]) begin
              e.rec.dir = face_dir_t'(d);
              e.rec.x = 4'(x);
              e.rec.y = 4'(y);
              e.rec.z = 4'(z);
              e.rec.ftype = cell_types[idx];
              e.rec.base = vtx_count;
              e.last = (open_mask >> (d + 1)) == 6'd0;
              pending_faces.insert(pending_faces.size(), e);
              vtx_count = vtx_count + COUNT_BITS'(4);
            end
          end
        end
      end
      default: ;  // The unused code leaves everything as it is.
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 50) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_error($sformatf("%s is %0d, expected %0d (face at %0d,%0d,%0d)",
                             name, got, exp_val, want.rec.x, want.rec.y,
                             want.rec.z));
  endtask

  // Every accepted record is matched against the oldest prediction. Values
  // are read at the edge itself, before any nonblocking update of that step.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_rec = m_tdata;
      if (pending_faces.size() == 0) begin
        report_error($sformatf("face record %h arrived with none expected",
                               m_tdata));
      end else begin
        want = pending_faces.pop_front();
        check_field("face_dir", 32'(got_rec.dir), 32'(want.rec.dir));
        check_field("face_x", 32'(got_rec.x), 32'(want.rec.x));
        check_field("face_y", 32'(got_rec.y), 32'(want.rec.y));
        check_field("face_z", 32'(got_rec.z), 32'(want.rec.z));
        check_field("face_type", 32'(got_rec.ftype), 32'(want.rec.ftype));
        check_field("base_vertex", 32'(got_rec.base), 32'(want.rec.base));
        check_field("last", 32'(m_tlast), 32'(want.last));
      end
    end
  end

  // The receiver alternates open runs and stalls of random length, so stalls
  // land on any record of a query.
  always @(posedge clk) begin
    if (rx_run == 0) begin
      rx_open = !rx_open;
      rx_run = rx_open ? $urandom_range(1, 30) : $urandom_range(1, 5);
      m_tready <= rx_open;
    end
    rx_run--;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Sends one word and waits for it to be taken. The sender works in bursts;
  // valid stays high inside a burst and drops only for a gap, which keeps a
  // single nonblocking write to s_tvalid per time step.
  task automatic send_word(input logic [23:0] w);
    s_tdata <= w;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_faces(w);
    if (w[1:0] != FUNC_UNUSED) words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  task automatic write_cell(input int x, input int y, input int z,
                            input logic [7:0] t);
    send_word({2'b00, t, 4'(z), 4'(y), 4'(x), FUNC_WRITE});
  endtask

  task automatic query_cell(input int x, input int y, input int z);
    send_word({2'b00, 8'h00, 4'(z), 4'(y), 4'(x), FUNC_QUERY});
  endtask

  task automatic begin_mesh();
    send_word({2'b00, 8'h00, 12'h000, FUNC_BEGIN});
  endtask

  // Stops the input and waits until every predicted face has arrived, then
  // lets the block finish any word that causes no record.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_faces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The air type is only changed while the block has nothing in flight.
  task automatic set_air(input logic [7:0] v);
    wait_idle();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    air_code = v;
  endtask

  // Coordinates lean toward the grid faces and a small central cluster, so
  // edges are hit often and neighbouring cells get written and overwritten.
  function automatic int pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) * 15;
      1: return $urandom_range(0, 15);
      default: return $urandom_range(6, 9);
    endcase
  endfunction

  // Mostly air or a handful of solid codes, sometimes any code at all.
  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return air_code;
      4, 5, 6, 7: return air_code + 8'($urandom_range(1, 4));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Writes the cell and each in-grid neighbour that holds no value yet, so a
  // query never reads a cell that was never written.
  task automatic fill_hood(input int x, input int y, input int z);
    int nx, ny, nz;
    for (int d = 0; d <= NUM_FACES; d++) begin
      nbr_of(d, x, y, z, nx, ny, nz);
      if (in_grid(nx, ny, nz) && !cell_written[cell_index(nx, ny, nz)])
        write_cell(nx, ny, nz, pick_type());
    end
  endtask

  task automatic run_random(input int n_words);
    int start, x, y, z, nx, ny, nz;
    start = words_sent;
    while (words_sent - start < n_words) begin
      case ($urandom_range(0, 19))
        // Well-formed query: touch up a few cells around it, make sure the
        // whole neighbourhood is loaded, then ask for its faces.
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: begin
          x = pick_coord();
          y = pick_coord();
          z = pick_coord();
          repeat ($urandom_range(0, 2)) begin
            nbr_of($urandom_range(0, NUM_FACES), x, y, z, nx, ny, nz);
            if (in_grid(nx, ny, nz)) write_cell(nx, ny, nz, pick_type());
          end
          fill_hood(x, y, z);
          query_cell(x, y, z);
        end
        13, 14, 15, 16: write_cell(pick_coord(), pick_coord(), pick_coord(),
                                   pick_type());
        17, 18: begin_mesh();
        default: send_word({2'b00, 20'($urandom), FUNC_UNUSED});
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Runs with the air type left at its reset value of zero.
  task automatic test_directed();
    begin_mesh();
    // A corner cell with air on its three inner sides: all six faces show,
    // three of them at the grid boundary.
    write_cell(0, 0, 0, 8'hFF);
    write_cell(1, 0, 0, 8'h00);
    write_cell(0, 1, 0, 8'h00);
    write_cell(0, 0, 1, 8'h00);
    query_cell(0, 0, 0);
    // The unused function code with every other bit set must be ignored.
    send_word({2'b00, 20'hFFFFF, FUNC_UNUSED});
    // The far corner with a solid neighbour on -X: five faces, the last on +X.
    write_cell(15, 15, 15, 8'h42);
    write_cell(14, 15, 15, 8'h01);
    write_cell(15, 14, 15, 8'h00);
    write_cell(15, 15, 14, 8'h00);
    query_cell(15, 15, 15);
    // A begin word restarts the base vertex at zero.
    begin_mesh();
    query_cell(0, 0, 0);
    // A cell enclosed on all sides gives no record.
    write_cell(8, 8, 8, 8'hA5);
    write_cell(8, 8, 9, 8'h5A);
    write_cell(8, 8, 7, 8'h5A);
    write_cell(8, 9, 8, 8'h5A);
    write_cell(8, 7, 8, 8'h5A);
    write_cell(9, 8, 8, 8'h5A);
    write_cell(7, 8, 8, 8'h5A);
    query_cell(8, 8, 8);
    // The same cell turned to air gives no record either.
    write_cell(8, 8, 8, 8'h00);
    query_cell(8, 8, 8);
  endtask

  // Random words under several air types, the extremes among them.
  task automatic test_random_air();
    set_air(8'hFF);
    run_random(85);
    set_air(8'($urandom_range(1, 254)));
    run_random(85);
    set_air(8'h00);
    run_random(85);
    set_air(8'h80);
    run_random(85);
  endtask

  // An isolated solid cell queried over and over shows all six faces each
  // time, with the base vertex stepping on across the queries.
  task automatic test_isolated_cell();
    int nx, ny, nz;
    set_air(8'($urandom_range(0, 255)));
    write_cell(5, 9, 2, air_code ^ 8'h3C);
    for (int d = 0; d < NUM_FACES; d++) begin
      nbr_of(d, 5, 9, 2, nx, ny, nz);
      write_cell(nx, ny, nz, air_code);
    end
    begin_mesh();
    repeat (REPEAT_QUERIES) query_cell(5, 9, 2);
  endtask

  initial begin
    for (int i = 0; i < GRID_CELLS; i++) begin
      cell_types[i] = '0;
      cell_written[i] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_air();
    test_isolated_cell();
    wait_idle();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop, several times the slowest correct run.
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/vfc_pkg.sv
rtl/voxel_face_culler.sv
tb/sv/voxel_face_culler_tb.sv
